### rtl/rhc_pkg.sv
// Package for the RGB to HSV converter: field widths, conversion constants
// and the record that moves down the divider chain. Depends on nothing.
package rhc_pkg;

   // Field widths.
   localparam int CH_W  = 8;
   localparam int HUE_W = 10;
   localparam int SAT_W = 8;

   // Quotient bits per division (hue reaches 360) and partial remainder width.
   localparam int QUO_W = 9;
   localparam int REM_W = 17;

   // Conversion constants.
   localparam int HUE_SCALE      = 60;
   localparam int SAT_SCALE      = 255;
   localparam int BASE_RED_MIN   = 3;
   localparam int BASE_GREEN_MIN = 5;
   localparam int BASE_OTHER     = 1;
   localparam logic signed [HUE_W-1:0] HUE_GRAY = -10'sd1;

   // Record handed from stage to stage: two restoring divisions run side by side.
   typedef struct packed {
      logic [REM_W-1:0] hue_rem;
      logic [REM_W-1:0] hue_div;
      logic [QUO_W-1:0] hue_quo;
      logic [REM_W-1:0] sat_rem;
      logic [REM_W-1:0] sat_div;
      logic [QUO_W-1:0] sat_quo;
      logic             gray;
      logic [CH_W-1:0]  val;
   } rhc_stage_type;

endpackage

### rtl/rhc_if.sv
// Request and response channel interfaces of the RGB to HSV converter.
// Depends on rhc_pkg for the field widths.
interface rhc_req_if;
   logic                      valid;
   logic                      ready;
   logic [rhc_pkg::CH_W-1:0]  red_in;
   logic [rhc_pkg::CH_W-1:0]  green_in;
   logic [rhc_pkg::CH_W-1:0]  blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface rhc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rhc_pkg::HUE_W-1:0]  hue_out;
   logic [rhc_pkg::SAT_W-1:0]         sat_out;
   logic [rhc_pkg::CH_W-1:0]          val_out;

   modport source (output valid, output hue_out, output sat_out, output val_out,
                   input ready);
   modport sink   (input valid, input hue_out, input sat_out, input val_out,
                   output ready);
endinterface

### rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front stage followed by a chain of
// divider cells. Depends on rhc_pkg, rhc_if, rhc_front and rhc_div_cell.
//
//   channel | dir | fields                       | handshake
//   req     | in  | red_in, green_in, blue_in    | valid / ready
//   rsp     | out | hue_out, sat_out, val_out    | valid / ready
//
// One pixel enters per clock unless a stall on the response side backs up the chain.
// The chain is one front stage plus one cell per quotient bit (9 cells).
// Each stage holds its item under stall and refills its bubbles independently.
// Reset clears only the stage valid flags; the data registers are not reset.
module rgb_to_hsv_converter (
   input  logic      clock,
   input  logic      reset,
   rhc_req_if.sink   req,
   rhc_rsp_if.source rsp
);
   import rhc_pkg::*;

   logic          stage_valid [QUO_W+1];
   logic          stage_ready [QUO_W+1];
   rhc_stage_type stage_data  [QUO_W+1];
   rhc_stage_type last;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   // One cell per quotient bit, most significant bit first.
   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // The last cell is the output register; gray pixels override the quotients.
   assign last              = stage_data[QUO_W];
   assign rsp.valid         = stage_valid[QUO_W];
   assign stage_ready[QUO_W] = rsp.ready;
   assign rsp.hue_out = last.gray ? HUE_GRAY : $signed(HUE_W'(last.hue_quo));
   assign rsp.sat_out = last.gray ? '0 : last.sat_quo[SAT_W-1:0];
   assign rsp.val_out = last.val;

`ifndef NO_ASSERTIONS
   // A gray result carries zero saturation.
   a_gray_sat : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.hue_out == HUE_GRAY) |-> (rsp.sat_out == '0))
      else $error("gray result with nonzero saturation");

   // A colored result has hue in range and nonzero saturation.
   a_color_range : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.hue_out != HUE_GRAY) |->
         (rsp.hue_out >= 0 && rsp.hue_out <= 10'sd360 && rsp.sat_out != '0))
      else $error("colored result out of range");

   // A colored result comes from a pixel with a nonzero largest channel.
   a_color_val : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !last.gray) |-> (rsp.val_out != '0))
      else $error("colored result with zero value");

   // Requests are refused only when the whole chain is full and stalled.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready && stage_valid[0]))
      else $error("request refused while the chain has room");
`endif

endmodule

### rtl/rhc_front.sv
// Front stage: finds max, min and sector, and forms both dividends and divisors.
// Depends on rhc_pkg and rhc_if.
module rhc_front (
   input  logic                   clock,
   input  logic                   reset,
   rhc_req_if.sink                req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rhc_pkg::rhc_stage_type out_data
);
   import rhc_pkg::*;

   logic [CH_W-1:0]        r, g, b;
   logic [CH_W-1:0]        mx, mn, d;
   logic [2:0]             base;
   logic signed [CH_W:0]   f;
   logic signed [11:0]     span;
   logic [10:0]            base_d;
   logic [REM_W-1:0]       hue_num;
   logic [REM_W-1:0]       sat_num;
   logic                   valid_ff, valid_in;
   rhc_stage_type          data_ff, data_in;

   assign r = req.red_in;
   assign g = req.green_in;
   assign b = req.blue_in;

   // Largest and smallest channel.
   always_comb begin
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
   end

   assign d = mx - mn;

   // Sector base and offset; red wins a tie for the minimum, then green.
   always_comb begin
      if (r == mn) begin
         base = 3'(BASE_RED_MIN);
         f    = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g == mn) begin
         base = 3'(BASE_GREEN_MIN);
         f    = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         base = 3'(BASE_OTHER);
         f    = $signed({1'b0, r}) - $signed({1'b0, g});
      end
   end

   // The offset lies within plus or minus d, so the span is never negative.
   assign base_d  = 11'(base) * 11'(d);
   assign span    = $signed({1'b0, base_d}) - 12'(f);
   assign hue_num = REM_W'(span[10:0]) * REM_W'(HUE_SCALE);
   assign sat_num = REM_W'(d) * REM_W'(SAT_SCALE);

   // Dividends enter as the first partial remainders; divisors are pre-aligned.
   always_comb begin
      data_in.hue_rem = hue_num;
      data_in.hue_div = REM_W'(d) << (QUO_W - 1);
      data_in.hue_quo = '0;
      data_in.sat_rem = sat_num;
      data_in.sat_div = REM_W'(mx) << (QUO_W - 1);
      data_in.sat_quo = '0;
      data_in.gray    = (d == '0);
      data_in.val     = mx;
   end

   assign req.ready = !valid_ff || out_ready;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/rhc_div_cell.sv
// One cell of the divider chain: a restoring step for hue and for saturation.
// Depends on rhc_pkg.
module rhc_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rhc_pkg::rhc_stage_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rhc_pkg::rhc_stage_type out_data
);
   import rhc_pkg::*;

   logic          hue_take, sat_take;
   logic          valid_ff, valid_in;
   rhc_stage_type data_ff, data_in;

   assign hue_take = in_data.hue_rem >= in_data.hue_div;
   assign sat_take = in_data.sat_rem >= in_data.sat_div;

   // Subtract when the divisor fits, shift the remainder, append a quotient bit.
   always_comb begin
      data_in = in_data;
      if (hue_take) begin
         data_in.hue_rem = (in_data.hue_rem - in_data.hue_div) << 1;
      end else begin
         data_in.hue_rem = in_data.hue_rem << 1;
      end
      if (sat_take) begin
         data_in.sat_rem = (in_data.sat_rem - in_data.sat_div) << 1;
      end else begin
         data_in.sat_rem = in_data.sat_rem << 1;
      end
      data_in.hue_quo = {in_data.hue_quo[QUO_W-2:0], hue_take};
      data_in.sat_quo = {in_data.sat_quo[QUO_W-2:0], sat_take};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
